>>> rtl/countdown_session_timer_unit_macros.svh
// Assertion macros for the countdown session timer unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef COUNTDOWN_SESSION_TIMER_UNIT_MACROS_SVH
`define COUNTDOWN_SESSION_TIMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CSTU_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("countdown timer: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define CSTU_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("countdown timer: next-cycle check failed");

`endif

>>> rtl/cstu_pkg.sv
// Shared types, constants and helper functions for the countdown session timer.
// No dependencies; used by every module of the unit.
package cstu_pkg;

   // Field widths
   localparam int SEC_W        = 14;
   localparam int MS_W         = 10;
   localparam int MIN_W        = 8;
   localparam int AGE_W        = 16;
   localparam int PRESET_IDX_W = 3;
   localparam int PRESET_REGS  = 5;

   // Register map indexes
   localparam logic [2:0] REG_PRESET_0 = 3'd0;
   localparam logic [2:0] REG_PRESET_1 = 3'd1;
   localparam logic [2:0] REG_PRESET_2 = 3'd2;
   localparam logic [2:0] REG_PRESET_3 = 3'd3;
   localparam logic [2:0] REG_PRESET_4 = 3'd4;
   localparam logic [2:0] REG_INTERVAL = 3'd5;

   // Reset values of the registers
   localparam logic [MIN_W-1:0] PRESET_RST_0 = 8'd25;
   localparam logic [MIN_W-1:0] PRESET_RST_1 = 8'd45;
   localparam logic [MIN_W-1:0] PRESET_RST_2 = 8'd15;
   localparam logic [MIN_W-1:0] PRESET_RST_3 = 8'd5;
   localparam logic [MIN_W-1:0] PRESET_RST_4 = 8'd90;
   localparam logic [AGE_W-1:0] INTERVAL_RST = 16'd30000;

   // Arithmetic constants
   localparam logic [MS_W-1:0]  MS_LAST      = 10'd999;
   localparam logic [AGE_W-1:0] AGE_MAX      = 16'hFFFF;
   localparam int               MINUTE_ROUND = 59;
   // floor(x/60) == (x * 17477) >> 20 for every x below 23000, which covers 2^14 + 59
   localparam int               RECIP_60     = 17477;
   localparam int               RECIP_SHIFT  = 20;

   // Button codes
   localparam logic BUTTON_A = 1'b0;
   localparam logic BUTTON_B = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_PAUSED  = 2'd2,
      MODE_DONE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_CLICK = 2'd1,
      OP_HOLD  = 2'd2,
      OP_ENTER = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REPAINT_NONE    = 2'd0,
      REPAINT_PARTIAL = 2'd1,
      REPAINT_FULL    = 2'd2
   } repaint_type;

   typedef struct packed {
      opcode_type opcode;
      logic       button;
   } item_type;

   typedef struct packed {
      mode_type          mode;
      logic [SEC_W-1:0]  remaining_seconds;
      logic [MIN_W-1:0]  minutes_left;
      repaint_type       repaint;
      logic              alarm;
      logic              handled;
      logic              heartbeat;
   } result_type;

   typedef struct packed {
      logic [PRESET_REGS-1:0][MIN_W-1:0] preset;
      logic [AGE_W-1:0]                  interval;
   } cfg_type;

   // Seconds divided by sixty, rounded up, kept to eight bits
   function automatic logic [MIN_W-1:0] minutes_of(input logic [SEC_W-1:0] sec);
      logic [SEC_W:0] x;
      logic [31:0]    prod;
      x    = (SEC_W+1)'(sec) + (SEC_W+1)'(MINUTE_ROUND);
      prod = 32'(x) * 32'(RECIP_60);
      return MIN_W'(prod >> RECIP_SHIFT);
   endfunction

   // Minutes times sixty as shift and subtract
   function automatic logic [SEC_W-1:0] preset_seconds(input logic [MIN_W-1:0] mins);
      logic [15:0] w;
      w = (16'(mins) << 6) - (16'(mins) << 2);
      return SEC_W'(w);
   endfunction

endpackage

>>> rtl/countdown_session_timer_unit.sv
// Countdown session timer. One transaction per clock cycle is taken in while the result side
// does not hold the flow, and one result per transaction comes out, in order; an accepted
// transaction is held in the input register, then passes the single-pass state update into the
// result register, from which rsp_ takes it. The sustained rate is one transaction per cycle,
// set by the single-pass state update; back-pressure on the result side stalls the input only
// once both registers are full. No clearing pass after reset. Configuration is written
// through the csr_ port; the user is to write it only while idle, the block does not enforce it.
`include "countdown_session_timer_unit_macros.svh"

module countdown_session_timer_unit #(
   parameter int PRESET_SLOTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] button, [7:1] zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] mode, [15:2] remaining_seconds,
                                    // [23:16] minutes_left, [25:24] repaint, [26] alarm,
                                    // [27] handled, [28] heartbeat, [31:29] zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cstu_pkg::cfg_type    cfg;
   cstu_pkg::item_type   item_ff;
   cstu_pkg::result_type result;
   cstu_pkg::result_type out_ff;
   logic                 in_valid_ff;
   logic                 out_valid_ff;
   logic                 advance;
   logic                 fire;
   logic                 req_take;

   // Pipeline control: the result register drains or is empty
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.opcode <= cstu_pkg::opcode_type'(req_tuser);
         item_ff.button <= req_tdata[0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   cstu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cstu_core #(
      .PRESET_SLOTS (PRESET_SLOTS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Output packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.heartbeat, out_ff.handled, out_ff.alarm,
                        out_ff.repaint, out_ff.minutes_left, out_ff.remaining_seconds,
                        out_ff.mode};

   // Checks
   `CSTU_ASSERT_IMP(a_alarm_done, clock, reset, out_valid_ff && out_ff.alarm,
      (out_ff.mode == cstu_pkg::MODE_DONE) && (out_ff.repaint == cstu_pkg::REPAINT_FULL))
   `CSTU_ASSERT_IMP(a_done_zero, clock, reset,
      out_valid_ff && (out_ff.mode == cstu_pkg::MODE_DONE),
      (out_ff.remaining_seconds == '0) && (out_ff.minutes_left == '0))
   `CSTU_ASSERT_IMP(a_handled_full, clock, reset, out_valid_ff && out_ff.handled,
      out_ff.repaint == cstu_pkg::REPAINT_FULL)
   `CSTU_ASSERT_NXT(a_stall_keeps_item, clock, reset, in_valid_ff && !advance,
      in_valid_ff && out_valid_ff)

endmodule

>>> rtl/cstu_csr.sv
// APB-style register file for the countdown session timer: presets and interval.
// Depends on cstu_pkg for the register map and reset values.
module cstu_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output cstu_pkg::cfg_type  cfg
);

   logic [cstu_pkg::PRESET_REGS-1:0][cstu_pkg::MIN_W-1:0] preset_ff;
   logic [cstu_pkg::AGE_W-1:0]                            interval_ff;
   logic [2:0]                                            reg_idx;
   logic                                                  wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff[0] <= cstu_pkg::PRESET_RST_0;
         preset_ff[1] <= cstu_pkg::PRESET_RST_1;
         preset_ff[2] <= cstu_pkg::PRESET_RST_2;
         preset_ff[3] <= cstu_pkg::PRESET_RST_3;
         preset_ff[4] <= cstu_pkg::PRESET_RST_4;
         interval_ff  <= cstu_pkg::INTERVAL_RST;
      end else if (wr_en) begin
         case (reg_idx)
            cstu_pkg::REG_PRESET_0: preset_ff[0] <= csr_pwdata[7:0];
            cstu_pkg::REG_PRESET_1: preset_ff[1] <= csr_pwdata[7:0];
            cstu_pkg::REG_PRESET_2: preset_ff[2] <= csr_pwdata[7:0];
            cstu_pkg::REG_PRESET_3: preset_ff[3] <= csr_pwdata[7:0];
            cstu_pkg::REG_PRESET_4: preset_ff[4] <= csr_pwdata[7:0];
            cstu_pkg::REG_INTERVAL: interval_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         cstu_pkg::REG_PRESET_0: csr_prdata = 32'(preset_ff[0]);
         cstu_pkg::REG_PRESET_1: csr_prdata = 32'(preset_ff[1]);
         cstu_pkg::REG_PRESET_2: csr_prdata = 32'(preset_ff[2]);
         cstu_pkg::REG_PRESET_3: csr_prdata = 32'(preset_ff[3]);
         cstu_pkg::REG_PRESET_4: csr_prdata = 32'(preset_ff[4]);
         cstu_pkg::REG_INTERVAL: csr_prdata = 32'(interval_ff);
         default:                csr_prdata = 32'd0;
      endcase
   end

   assign cfg.preset   = preset_ff;
   assign cfg.interval = interval_ff;

endmodule

>>> rtl/cstu_core.sv
// Timer state and single-pass next-state logic of the countdown session timer.
// Depends on cstu_pkg; produces one result per processed transaction.
module cstu_core #(
   parameter int PRESET_SLOTS = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  cstu_pkg::item_type    item,
   input  cstu_pkg::cfg_type     cfg,
   output cstu_pkg::result_type  result
);

   localparam int SLOT_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PRESET_SLOTS - 1);

   cstu_pkg::mode_type             mode_ff, mode_in;
   logic [SLOT_W-1:0]              slot_ff, slot_in;
   logic [cstu_pkg::SEC_W-1:0]     left_sec_ff, left_sec_in;
   logic [cstu_pkg::MS_W-1:0]      frac_ff, frac_in;
   logic [cstu_pkg::SEC_W-1:0]     held_ff, held_in;
   logic [cstu_pkg::MIN_W-1:0]     shown_min_ff, shown_min_in;
   logic                           known_ff, known_in;
   logic [cstu_pkg::AGE_W-1:0]     age_ff, age_in;
   logic                           hb_ff, hb_in;

   logic [cstu_pkg::PRESET_IDX_W-1:0] slot_idx;
   logic [cstu_pkg::MIN_W-1:0]        preset_min;
   logic [cstu_pkg::SEC_W-1:0]        preset_sec;
   logic [cstu_pkg::SEC_W-1:0]        sec_next;
   logic [cstu_pkg::MIN_W-1:0]        min_next;
   logic [cstu_pkg::AGE_W-1:0]        age_tick;
   logic                              draw;
   cstu_pkg::repaint_type             repaint;
   logic                              alarm;
   logic                              handled;

   // Mode, slot and countdown registers
   always_comb begin
      mode_in     = mode_ff;
      slot_in     = slot_ff;
      left_sec_in = left_sec_ff;
      frac_in     = frac_ff;
      held_in     = held_ff;
      case (item.opcode)
         cstu_pkg::OP_TICK: begin
            if (mode_ff == cstu_pkg::MODE_RUNNING) begin
               if (frac_ff != '0) begin
                  frac_in = frac_ff - 1'b1;
               end else if (left_sec_ff != '0) begin
                  left_sec_in = left_sec_ff - 1'b1;
                  frac_in     = cstu_pkg::MS_LAST;
               end
               if (left_sec_in == '0) begin
                  mode_in = cstu_pkg::MODE_DONE;
               end
            end
         end
         cstu_pkg::OP_CLICK: begin
            if (mode_ff == cstu_pkg::MODE_IDLE) begin
               if (item.button == cstu_pkg::BUTTON_B) begin
                  slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
               end else begin
                  slot_in = (slot_ff == '0) ? LAST_SLOT : slot_ff - 1'b1;
               end
            end else begin
               mode_in = cstu_pkg::MODE_IDLE;
               held_in = '0;
            end
         end
         cstu_pkg::OP_HOLD: begin
            if (item.button == cstu_pkg::BUTTON_A) begin
               case (mode_ff)
                  cstu_pkg::MODE_IDLE: begin
                     left_sec_in = preset_sec;
                     frac_in     = '0;
                     mode_in     = cstu_pkg::MODE_RUNNING;
                  end
                  cstu_pkg::MODE_RUNNING: begin
                     held_in = left_sec_ff;
                     mode_in = cstu_pkg::MODE_PAUSED;
                  end
                  cstu_pkg::MODE_PAUSED: begin
                     left_sec_in = held_ff;
                     frac_in     = '0;
                     mode_in     = cstu_pkg::MODE_RUNNING;
                  end
                  default: begin
                     mode_in = cstu_pkg::MODE_IDLE;
                     held_in = '0;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   // Preset of the slot selected after this transaction; slots past the registers read zero
   assign slot_idx   = cstu_pkg::PRESET_IDX_W'(slot_in);
   assign preset_min = (32'(slot_idx) < cstu_pkg::PRESET_REGS) ? cfg.preset[slot_idx] : '0;
   assign preset_sec = cstu_pkg::preset_seconds(preset_min);

   // Seconds and minutes shown after this transaction
   always_comb begin
      case (mode_in)
         cstu_pkg::MODE_RUNNING: sec_next = left_sec_in;
         cstu_pkg::MODE_PAUSED:  sec_next = held_in;
         cstu_pkg::MODE_DONE:    sec_next = '0;
         default:                sec_next = preset_sec;
      endcase
   end

   assign min_next = cstu_pkg::minutes_of(sec_next);
   assign age_tick = (age_ff != cstu_pkg::AGE_MAX) ? age_ff + 1'b1 : age_ff;

   // Paint age, heartbeat, screen tracking and result flags
   always_comb begin
      age_in  = age_ff;
      hb_in   = hb_ff;
      known_in = known_ff;
      draw    = 1'b0;
      repaint = cstu_pkg::REPAINT_NONE;
      alarm   = 1'b0;
      handled = 1'b0;
      case (item.opcode)
         cstu_pkg::OP_TICK: begin
            age_in = age_tick;
            if (mode_ff == cstu_pkg::MODE_RUNNING) begin
               if (mode_in == cstu_pkg::MODE_DONE) begin
                  repaint = cstu_pkg::REPAINT_FULL;
                  alarm   = 1'b1;
                  draw    = 1'b1;
               end else if (!known_ff || (min_next != shown_min_ff) ||
                            (age_tick >= cfg.interval)) begin
                  age_in  = '0;
                  hb_in   = ~hb_ff;
                  repaint = cstu_pkg::REPAINT_PARTIAL;
                  draw    = 1'b1;
               end
            end
         end
         cstu_pkg::OP_CLICK: begin
            repaint = cstu_pkg::REPAINT_FULL;
            handled = 1'b1;
            draw    = 1'b1;
         end
         cstu_pkg::OP_HOLD: begin
            if (item.button == cstu_pkg::BUTTON_A) begin
               if (mode_ff == cstu_pkg::MODE_IDLE) begin
                  age_in = '0;
                  hb_in  = 1'b1;
               end else if (mode_ff == cstu_pkg::MODE_PAUSED) begin
                  age_in = '0;
               end
               repaint = cstu_pkg::REPAINT_FULL;
               handled = 1'b1;
               draw    = 1'b1;
            end
         end
         default: begin
            age_in  = '0;
            repaint = cstu_pkg::REPAINT_FULL;
            draw    = 1'b1;
         end
      endcase
      // every repaint draws at once and leaves the current minutes on screen
      if (draw) begin
         known_in = 1'b1;
      end
   end

   assign shown_min_in = draw ? min_next : shown_min_ff;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cstu_pkg::MODE_IDLE;
         slot_ff      <= '0;
         left_sec_ff  <= '0;
         frac_ff      <= '0;
         held_ff      <= '0;
         shown_min_ff <= '0;
         known_ff     <= 1'b0;
         age_ff       <= '0;
         hb_ff        <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         slot_ff      <= slot_in;
         left_sec_ff  <= left_sec_in;
         frac_ff      <= frac_in;
         held_ff      <= held_in;
         shown_min_ff <= shown_min_in;
         known_ff     <= known_in;
         age_ff       <= age_in;
         hb_ff        <= hb_in;
      end
   end

   assign result.mode              = mode_in;
   assign result.remaining_seconds = sec_next;
   assign result.minutes_left      = min_next;
   assign result.repaint           = repaint;
   assign result.alarm             = alarm;
   assign result.handled           = handled;
   assign result.heartbeat         = hb_in;

endmodule
